// ===== src/suart_pkg.sv =====
// Shared types and constants for the 8N1 UART core.
`timescale 1ns / 1ps

package suart_pkg;

   // Request kinds carried on req_tuser
   typedef enum logic [1:0] {
      REQ_TICK  = 2'd0,
      REQ_WRITE = 2'd1,
      REQ_READ  = 2'd2,
      REQ_FLUSH = 2'd3
   } req_kind_type;

   localparam int RX_BITS       = 8;
   localparam int TX_BITS       = 10;
   localparam int BIT_TICKS     = 3;   // ticks per bit
   localparam int RX_FIRST_WAIT = 4;   // start edge to center of data bit 0

   // Request presented to the receiver for one pipeline step
   typedef struct packed {
      logic go;       // a request moves into the result stage this cycle
      logic tick;
      logic read;
      logic flush;
      logic pin;
      logic enable;
   } rx_cmd_type;

   // Receiver side of the result, registered
   typedef struct packed {
      logic [7:0] rx_data;
      logic       rx_valid;
      logic       pending;
   } rx_stat_type;

endpackage

// ===== src/suart_rx.sv =====
// Receiver bit sampler and receive ring FIFO.
`timescale 1ns / 1ps

module suart_rx #(
   parameter int FIFO_DEPTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  suart_pkg::rx_cmd_type  cmd,
   output suart_pkg::rx_stat_type stat
);
   import suart_pkg::*;

   localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);

   logic [7:0]       mem [FIFO_DEPTH];

   logic [7:0]       shift_ff, shift_in;
   logic [7:0]       mask_ff, mask_in;
   logic [2:0]       cnt_ff, cnt_in;
   logic [3:0]       bits_ff, bits_in;
   logic             in_frame_ff, in_frame_in;
   logic             await_ff, await_in;
   logic [PTR_W-1:0] wp_ff, wp_in;
   logic [PTR_W-1:0] rp_ff, rp_in;
   logic             push;
   logic             pop;
   logic [2:0]       cnt_dec;
   logic [3:0]       bits_dec;
   rx_stat_type      stat_ff;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      ptr_next = (p == PTR_LAST) ? '0 : p + 1'b1;
   endfunction

   assign cnt_dec  = cnt_ff - 3'd1;
   assign bits_dec = bits_ff - 4'd1;
   assign pop      = cmd.read && (rp_ff != wp_ff);

   always_comb begin
      shift_in    = shift_ff;
      mask_in     = mask_ff;
      cnt_in      = cnt_ff;
      bits_in     = bits_ff;
      in_frame_in = in_frame_ff;
      await_in    = await_ff;
      wp_in       = wp_ff;
      rp_in       = rp_ff;
      push        = 1'b0;
      if (cmd.tick && cmd.enable) begin
         if (await_ff) begin
            // stop bit is not checked, byte lands after one bit time
            cnt_in = cnt_dec;
            if (cnt_dec == 3'd0) begin
               await_in    = 1'b0;
               in_frame_in = 1'b0;
               push        = 1'b1;
               wp_in       = ptr_next(wp_ff);
            end
         end else if (!in_frame_ff) begin
            if (!cmd.pin) begin
               in_frame_in = 1'b1;
               shift_in    = '0;
               cnt_in      = 3'(RX_FIRST_WAIT);
               bits_in     = 4'(RX_BITS);
               mask_in     = 8'd1;
            end
         end else begin
            cnt_in = cnt_dec;
            if (cnt_dec == 3'd0) begin
               cnt_in = 3'(BIT_TICKS);
               if (cmd.pin) begin
                  shift_in = shift_ff | mask_ff;
               end
               mask_in = {mask_ff[6:0], 1'b0};
               bits_in = bits_dec;
               if (bits_dec == 4'd0) begin
                  await_in = 1'b1;
               end
            end
         end
      end
      if (pop) begin
         rp_in = ptr_next(rp_ff);
      end
      if (cmd.flush) begin
         wp_in = '0;
         rp_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff    <= '0;
         mask_ff     <= 8'd1;
         cnt_ff      <= '0;
         bits_ff     <= '0;
         in_frame_ff <= 1'b0;
         await_ff    <= 1'b0;
         wp_ff       <= '0;
         rp_ff       <= '0;
      end else if (cmd.go) begin
         shift_ff    <= shift_in;
         mask_ff     <= mask_in;
         cnt_ff      <= cnt_in;
         bits_ff     <= bits_in;
         in_frame_ff <= in_frame_in;
         await_ff    <= await_in;
         wp_ff       <= wp_in;
         rp_ff       <= rp_in;
      end
   end

   // FIFO storage: one write port, registered read into the result
   always_ff @(posedge clock) begin
      if (cmd.go && push) begin
         mem[wp_ff] <= shift_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.go) begin
         stat_ff.rx_data  <= pop ? mem[rp_ff] : 8'd0;
         stat_ff.rx_valid <= pop;
         stat_ff.pending  <= (rp_in != wp_in);
      end
   end

   assign stat = stat_ff;

endmodule

// ===== src/soft_uart_8n1_oversampled_core.sv =====
// Top level of the 8N1 UART core ticked at three times the baud rate.
`timescale 1ns / 1ps

// A request passes the input register, then the result register.
//   Throughput: one request per cycle, no bubbles, while rsp_tready is high.
// Reset (synchronous, active high) returns the line to idle high, clears the
//   transmitter, receiver and FIFO pointers and sets rx_enable to 1. FIFO
//   contents are not cleared; the pointers never expose an unwritten entry.

module soft_uart_8n1_oversampled_core #(
   parameter int FIFO_DEPTH = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   // request channel
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  suart_pkg::req_kind_type req_tuser,   // [1:0] req_type
   input  logic [15:0]             req_tdata,   // [0] rx_pin, [8:1] tx_byte, rest 0
   // response channel
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [15:0]             rsp_tdata,   // [0] tx_pin, [1] tx_busy,
                                                // [2] write_accepted, [10:3] rx_byte,
                                                // [11] rx_byte_valid, [12] rx_pending
   // configuration
   input  logic                    csr_wr_en,
   input  logic                    csr_wr_data  // rx_enable
);
   import suart_pkg::*;

   // input register
   logic         in_valid_ff;
   req_kind_type in_kind_ff;
   logic         in_pin_ff;
   logic [7:0]   in_byte_ff;

   // response register
   logic         rsp_valid_ff, rsp_valid_in;
   logic         tx_pin_ff;
   logic         tx_busy_ff;
   logic         accepted_ff, accepted_in;

   // config
   logic         rx_enable_ff;

   // transmitter state
   logic [9:0]   tx_shift_ff, tx_shift_in;
   logic [1:0]   tx_cnt_ff, tx_cnt_in;
   logic [3:0]   tx_bits_ff, tx_bits_in;
   logic         tx_active_ff, tx_active_in;
   logic         tx_level_ff, tx_level_in;
   logic [1:0]   tx_cnt_dec;
   logic [3:0]   tx_bits_dec;

   logic         advance;
   rx_cmd_type   rx_cmd;
   rx_stat_type  rx_stat;

   // a request leaves the input register when the result slot is free
   assign advance      = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready   = !in_valid_ff || advance;
   assign rsp_valid_in = advance ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_kind_ff <= req_tuser;
         in_pin_ff  <= req_tdata[0];
         in_byte_ff <= req_tdata[8:1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_enable_ff <= 1'b1;
      end else if (csr_wr_en) begin
         rx_enable_ff <= csr_wr_data;
      end
   end

   // Receiver steps on a tick alongside the transmitter; it is independent of it.
   assign rx_cmd.go     = advance;
   assign rx_cmd.tick   = (in_kind_ff == REQ_TICK);
   assign rx_cmd.read   = (in_kind_ff == REQ_READ);
   assign rx_cmd.flush  = (in_kind_ff == REQ_FLUSH);
   assign rx_cmd.pin    = in_pin_ff;
   assign rx_cmd.enable = rx_enable_ff;

   suart_rx #(
      .FIFO_DEPTH(FIFO_DEPTH)
   ) u_rx (
      .clock (clock),
      .reset (reset),
      .cmd   (rx_cmd),
      .stat  (rx_stat)
   );

   // Transmitter: start bit, 8 data bits LSB first, stop bit; the line
   // changes every third tick, the first change three ticks after the write.
   assign tx_cnt_dec  = tx_cnt_ff - 2'd1;
   assign tx_bits_dec = tx_bits_ff - 4'd1;

   always_comb begin
      tx_shift_in  = tx_shift_ff;
      tx_cnt_in    = tx_cnt_ff;
      tx_bits_in   = tx_bits_ff;
      tx_active_in = tx_active_ff;
      tx_level_in  = tx_level_ff;
      accepted_in  = 1'b0;
      unique case (in_kind_ff)
         REQ_TICK: begin
            if (tx_active_ff) begin
               tx_cnt_in = tx_cnt_dec;
               if (tx_cnt_dec == 2'd0) begin
                  tx_level_in = tx_shift_ff[0];
                  tx_shift_in = {1'b0, tx_shift_ff[9:1]};
                  tx_cnt_in   = 2'(BIT_TICKS);
                  tx_bits_in  = tx_bits_dec;
                  if (tx_bits_dec == 4'd0) begin
                     tx_active_in = 1'b0;
                  end
               end
            end
         end
         REQ_WRITE: begin
            // a write while a frame is in flight is dropped
            if (!tx_active_ff) begin
               tx_cnt_in    = 2'(BIT_TICKS);
               tx_bits_in   = 4'(TX_BITS);
               tx_shift_in  = {1'b1, in_byte_ff, 1'b0};
               tx_active_in = 1'b1;
               accepted_in  = 1'b1;
            end
         end
         REQ_READ, REQ_FLUSH: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_shift_ff  <= '1;
         tx_cnt_ff    <= 2'(BIT_TICKS);
         tx_bits_ff   <= '0;
         tx_active_ff <= 1'b0;
         tx_level_ff  <= 1'b1;
      end else if (advance) begin
         tx_shift_ff  <= tx_shift_in;
         tx_cnt_ff    <= tx_cnt_in;
         tx_bits_ff   <= tx_bits_in;
         tx_active_ff <= tx_active_in;
         tx_level_ff  <= tx_level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tx_pin_ff   <= tx_level_in;
         tx_busy_ff  <= tx_active_in;
         accepted_ff <= accepted_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'd0, rx_stat.pending, rx_stat.rx_valid, rx_stat.rx_data,
                        accepted_ff, tx_busy_ff, tx_pin_ff};

endmodule

// ===== test/tb_soft_uart_8n1_oversampled_core.sv =====
// Self-checking testbench for the 8N1 UART core ticked at three times the baud rate.
`timescale 1ns / 1ps

module tb_soft_uart_8n1_oversampled_core;
   import suart_pkg::*;

   localparam int STORE_DEPTH = 16;
   localparam int PTR_W       = $clog2(STORE_DEPTH);
   localparam int CYCLE_LIMIT = 100000;   // far above the slowest correct run

   // One response, packed as on rsp_tdata (lowest field in bit 0)
   typedef struct packed {
      logic       rx_pending;
      logic       rx_byte_valid;
      logic [7:0] rx_byte;
      logic       write_accepted;
      logic       tx_busy;
      logic       tx_pin;
   } uart_status_type;

   logic           clock       = 1'b0;
   logic           reset       = 1'b1;
   logic           req_tvalid  = 1'b0;
   logic           req_tready;
   req_kind_type   req_tuser   = REQ_TICK;
   logic [15:0]    req_tdata   = '0;     // [0] rx_pin, [8:1] tx_byte, rest 0
   logic           rsp_tvalid;
   logic           rsp_tready  = 1'b0;
   logic [15:0]    rsp_tdata;            // [0] tx_pin, [1] tx_busy, [2] write_accepted,
                                         // [10:3] rx_byte, [11] rx_byte_valid, [12] rx_pending
   logic           csr_wr_en   = 1'b0;
   logic           csr_wr_data = 1'b0;   // rx_enable

   // Pacing knobs, percent of cycles
   int send_idle_pct  = 20;
   int recv_stall_pct = 50;
   int hold_request   = 0;     // cycles of receiver hold-off asked by a test
   int error_count    = 0;
   int cycle_count    = 0;

   // Serial line shape for the receive pin
   int   line_noise_pct = 15;
   int   line_gap_max   = 4;
   logic rx_line_q[$];

   uart_status_type uart_status_q[$];   // expected responses, oldest first

   // ---------------------------------------------------------------------
   // Mirror of the core state
   // ---------------------------------------------------------------------
   logic             rx_on;
   logic [9:0]       tx_frame;
   logic [1:0]       tx_phase;
   logic [3:0]       tx_left;
   logic             tx_running;
   logic             tx_line;
   logic [7:0]       rx_data;
   logic [7:0]       rx_mask;
   logic [2:0]       rx_phase;
   logic [3:0]       rx_left;
   logic             rx_busy;
   logic             rx_stop_wait;
   logic [7:0]       rx_store [STORE_DEPTH];
   logic [PTR_W-1:0] store_wr;
   logic [PTR_W-1:0] store_rd;
   int               rx_captures = 0;   // bytes the receiver has stored so far

   soft_uart_8n1_oversampled_core #(
      .FIFO_DEPTH (STORE_DEPTH)
   ) i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tuser   (req_tuser),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #10 clock = ~clock;

   function automatic void reset_uart_state();
      rx_on        = 1'b1;
      tx_frame     = '1;
      tx_phase     = 2'd3;
      tx_left      = '0;
      tx_running   = 1'b0;
      tx_line      = 1'b1;     // line idles high
      rx_data      = '0;
      rx_mask      = 8'd1;
      rx_phase     = '0;
      rx_left      = '0;
      rx_busy      = 1'b0;
      rx_stop_wait = 1'b0;
      store_wr     = '0;
      store_rd     = '0;
      for (int i = 0; i < STORE_DEPTH; i++) rx_store[i] = '0;
   endfunction

   // Applies one request to the mirror and returns the response it gives.
   function automatic uart_status_type next_uart_status(req_kind_type kind, logic pin,
                                                        logic [7:0] data);
      uart_status_type st;
      logic [2:0]      rx_next;
      logic [1:0]      tx_next;
      st = '0;
      case (kind)
         REQ_TICK: begin
            // receiver samples first, then the transmitter steps
            if (rx_on) begin
               if (rx_stop_wait) begin
                  // stop bit is not looked at, the byte lands after three ticks
                  rx_phase = rx_phase - 3'd1;
                  if (rx_phase == 3'd0) begin
                     rx_stop_wait       = 1'b0;
                     rx_busy            = 1'b0;
                     rx_store[store_wr] = rx_data;
                     store_wr           = store_wr + 1'b1;   // no overrun check
                     rx_captures++;
                  end
               end else if (!rx_busy) begin
                  if (!pin) begin
                     // any low sample while idle is a start bit
                     rx_busy  = 1'b1;
                     rx_data  = '0;
                     rx_phase = 3'd4;
                     rx_left  = 4'd8;
                     rx_mask  = 8'd1;
                  end
               end else begin
                  rx_next = rx_phase - 3'd1;
                  if (rx_next == 3'd0) begin
                     rx_next = 3'd3;
                     if (pin) rx_data = rx_data | rx_mask;
                     rx_mask = rx_mask << 1;
                     rx_left = rx_left - 4'd1;
                     if (rx_left == 4'd0) rx_stop_wait = 1'b1;
                  end
                  rx_phase = rx_next;
               end
            end
            if (tx_running) begin
               tx_next = tx_phase - 2'd1;
               if (tx_next == 2'd0) begin
                  tx_line  = tx_frame[0];
                  tx_frame = tx_frame >> 1;
                  tx_next  = 2'd3;
                  tx_left  = tx_left - 4'd1;
                  if (tx_left == 4'd0) tx_running = 1'b0;
               end
               tx_phase = tx_next;
            end
         end
         REQ_WRITE: begin
            // a write while a frame is in flight is dropped
            if (!tx_running) begin
               tx_phase          = 2'd3;
               tx_left           = 4'd10;
               tx_frame          = {1'b1, data, 1'b0};
               tx_running        = 1'b1;
               st.write_accepted = 1'b1;
            end
         end
         REQ_READ: begin
            // empty read gives byte 0, not valid
            if (store_rd != store_wr) begin
               st.rx_byte       = rx_store[store_rd];
               st.rx_byte_valid = 1'b1;
               store_rd         = store_rd + 1'b1;
            end
         end
         REQ_FLUSH: begin
            store_wr = '0;
            store_rd = '0;
         end
      endcase
      st.tx_pin     = tx_line;
      st.tx_busy    = tx_running;
      st.rx_pending = (store_rd != store_wr);
      return st;
   endfunction

   // Next level of the receive line, one per tick. Mostly clean frames with a
   // random byte; some noisy frames and idle stretches in between.
   function automatic logic next_rx_level();
      logic [9:0] frame;
      int         roll;
      if (rx_line_q.size() == 0) begin
         roll  = $urandom_range(99, 0);
         frame = {1'b1, 8'($urandom_range(255, 0)), 1'b0};
         if (roll < line_noise_pct) frame = 10'($urandom_range(1023, 0));
         for (int k = 0; k < 10; k++) repeat (3) rx_line_q.push_back(frame[k]);
         repeat ($urandom_range(line_gap_max, 0)) rx_line_q.push_back(1'b1);
      end
      return rx_line_q.pop_front();
   endfunction

   // ---------------------------------------------------------------------
   // Request side: one request per call, random gaps ahead of it
   // ---------------------------------------------------------------------
   task automatic send_request(input req_kind_type kind, input logic pin,
                               input logic [7:0] data);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {7'd0, data, pin};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      // request taken at this edge
      uart_status_q.push_back(next_uart_status(kind, pin, data));
   endtask

   task automatic send_random_request(input int read_pct, input int write_pct,
                                      input int flush_pct);
      int           roll;
      req_kind_type kind;
      logic         pin;
      roll = $urandom_range(99, 0);
      if (roll < read_pct)                               kind = REQ_READ;
      else if (roll < read_pct + write_pct)              kind = REQ_WRITE;
      else if (roll < read_pct + write_pct + flush_pct)  kind = REQ_FLUSH;
      else                                               kind = REQ_TICK;
      // pin only matters on ticks; elsewhere it is random
      if (kind == REQ_TICK) pin = next_rx_level();
      else                  pin = 1'($urandom_range(1, 0));
      send_request(kind, pin, 8'($urandom_range(255, 0)));
   endtask

   // Stop offering requests and wait until every response is back
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      while (uart_status_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);   // pipeline is two deep
   endtask

   task automatic write_rx_enable(input logic value);
      drain_responses();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      rx_on = value;
      csr_wr_en <= 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------
   // Read and flush on an empty FIFO
   task automatic test_empty_fifo();
      send_request(REQ_READ, 1'b0, 8'h00);
      send_request(REQ_FLUSH, 1'b1, 8'hFF);
      send_request(REQ_READ, 1'b1, 8'hA5);
   endtask

   // Start a frame, then a write while busy; see the start bit go out
   task automatic test_transmit_busy();
      send_request(REQ_WRITE, 1'b0, 8'h00);
      send_request(REQ_WRITE, 1'b1, 8'hFF);   // rejected, frame in flight
      repeat (3) send_request(REQ_TICK, 1'b1, 8'h5A);
      send_request(REQ_TICK, 1'b0, 8'hFF);    // low sample opens a receive frame
      send_request(REQ_TICK, 1'b1, 8'h00);
      drain_responses();
   endtask

   task automatic test_mixed_traffic(input int count);
      line_noise_pct = 15;
      line_gap_max   = 4;
      repeat (count) send_random_request(12, 8, 2);
      drain_responses();
   endtask

   // Same traffic with the receiver held still
   task automatic test_receiver_frozen(input int count);
      repeat (count) send_random_request(12, 8, 2);
      drain_responses();
   endtask

   // Back-to-back clean frames and no reads: the write pointer laps the read
   // pointer, so one overwritten byte shows up and then the FIFO reads empty.
   task automatic test_fifo_overrun();
      int target;
      line_noise_pct = 0;
      line_gap_max   = 0;
      send_request(REQ_FLUSH, 1'b1, 8'h00);
      target = rx_captures + STORE_DEPTH + 1;
      while (rx_captures < target) send_random_request(0, 10, 0);
      repeat (3) send_request(REQ_READ, 1'($urandom_range(1, 0)),
                              8'($urandom_range(255, 0)));
      drain_responses();
   endtask

   // Receiver holds off for a long stretch while requests keep coming, so the
   // core fills up and drops req_tready.
   task automatic test_backpressure(input int count);
      line_noise_pct = 15;
      line_gap_max   = 4;
      hold_request   = 150;
      repeat (count) send_random_request(20, 8, 2);
      drain_responses();
   endtask

   // ---------------------------------------------------------------------
   // Response side
   // ---------------------------------------------------------------------
   always @(posedge clock) begin : drive_ready
      int hold_left;
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left--;
      end else if (hold_request > 0) begin
         hold_left    = hold_request - 1;
         hold_request = 0;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
      end
   end

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
         error_count++;
      end
   endfunction

   always @(posedge clock) begin : check_responses
      uart_status_type got;
      uart_status_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[12:0];
         if (uart_status_q.size() == 0) begin
            $display("%0t: response with none expected, expected none actual %h",
                     $time, rsp_tdata);
            error_count++;
         end else begin
            want = uart_status_q.pop_front();
            check_field("tx_pin", want.tx_pin, got.tx_pin);
            check_field("tx_busy", want.tx_busy, got.tx_busy);
            check_field("write_accepted", want.write_accepted, got.write_accepted);
            check_field("rx_byte", want.rx_byte, got.rx_byte);
            check_field("rx_byte_valid", want.rx_byte_valid, got.rx_byte_valid);
            check_field("rx_pending", want.rx_pending, got.rx_pending);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_soft_uart_8n1_oversampled_core failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------
   initial begin
      reset_uart_state();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // sender idles 20%, receiver stalls 50%
      send_idle_pct  = 20;
      recv_stall_pct = 50;
      test_empty_fifo();
      test_transmit_busy();
      test_mixed_traffic(150);

      // and the other way round, with the receiver frozen
      write_rx_enable(1'b0);
      send_idle_pct  = 50;
      recv_stall_pct = 20;
      test_receiver_frozen(80);

      // full rate on both sides
      write_rx_enable(1'b1);
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      test_fifo_overrun();
      test_backpressure(60);

      repeat (8) @(posedge clock);
      if (error_count == 0 && uart_status_q.size() == 0) begin
         $display("tb_soft_uart_8n1_oversampled_core passed");
      end else begin
         $display("tb_soft_uart_8n1_oversampled_core failed");
      end
      $finish;
   end

endmodule

// ===== soft_uart_8n1_oversampled_core.f =====
src/suart_pkg.sv
src/suart_rx.sv
src/soft_uart_8n1_oversampled_core.sv
test/tb_soft_uart_8n1_oversampled_core.sv
